[rtl/ezl_pkg.sv]
package ezl_pkg;

  // Signatures as seen in a 32-bit window, oldest byte in the top bits
  localparam logic [31:0] SIG_HEADER = 32'h504B_0304;
  localparam logic [31:0] SIG_EOCD   = 32'h504B_0506;

  // EOCD record layout
  localparam int unsigned EOCD_FIXED_SIZE = 22;
  localparam int unsigned CMT_OFFSET      = 20;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_HDR    = 3'd1;
  localparam logic [2:0] ST_NO_EOCD   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;

  typedef logic [2:0] status_t;

  // Flags of one finished file, handed from the scanner to the result stage
  typedef struct packed {
    logic hdr_seen;
    logic eocd_seen;
  } ezl_flags_t;

endpackage

[rtl/ezl_scan.sv]
module ezl_scan #(
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last_byte,
  input  logic                     fin_take,
  output logic                     fin_valid,
  output ezl_pkg::ezl_flags_t      fin_flags,
  output logic [POSITION_BITS-1:0] fin_pos,
  output logic [POSITION_BITS-1:0] fin_hdr_off,
  output logic [POSITION_BITS-1:0] fin_eocd_off,
  output logic [15:0]              fin_cmt
);

  localparam int P = POSITION_BITS;

  // Scan state
  logic [P-1:0]  pos_r;
  logic [23:0]   recent_r;
  logic          hdr_seen_r;
  logic [P-1:0]  hdr_off_r;
  logic          eocd_seen_r;
  logic [P-1:0]  eocd_off_r;
  logic [15:0]   cmt_r;

  logic          hdr_seen_nxt;
  logic [P-1:0]  hdr_off_nxt;
  logic          eocd_seen_nxt;
  logic [P-1:0]  eocd_off_nxt;
  logic [15:0]   cmt_nxt;

  // Snapshot of a finished file
  logic                 fin_valid_r;
  ezl_pkg::ezl_flags_t  fin_flags_r;
  logic [P-1:0]         fin_pos_r;
  logic [P-1:0]         fin_hdr_off_r;
  logic [P-1:0]         fin_eocd_off_r;
  logic [15:0]          fin_cmt_r;

  logic [31:0]   window;
  logic          hdr_hit;
  logic          eocd_hit;
  logic [P-1:0]  sig_start;
  logic [P-1:0]  eocd_dist;
  logic          accept;

  assign in_ready  = !fin_valid_r || fin_take;
  assign accept    = in_valid && in_ready;

  assign window    = {recent_r, in_data_byte};
  assign hdr_hit   = (window == ezl_pkg::SIG_HEADER);
  assign eocd_hit  = (window == ezl_pkg::SIG_EOCD);
  assign sig_start = pos_r - P'(3);
  assign eocd_dist = pos_r - eocd_off_r;

  // Track first header, last EOCD and its comment length
  always_comb begin
    hdr_seen_nxt  = hdr_seen_r | hdr_hit;
    hdr_off_nxt   = (hdr_hit && !hdr_seen_r) ? sig_start : hdr_off_r;
    eocd_seen_nxt = eocd_seen_r;
    eocd_off_nxt  = eocd_off_r;
    cmt_nxt       = cmt_r;
    if (eocd_hit) begin
      eocd_seen_nxt = 1'b1;
      eocd_off_nxt  = sig_start;
      cmt_nxt       = '0;
    end else if (eocd_seen_r) begin
      if (eocd_dist == P'(ezl_pkg::CMT_OFFSET)) begin
        cmt_nxt[7:0] = in_data_byte;
      end else if (eocd_dist == P'(ezl_pkg::CMT_OFFSET + 1)) begin
        cmt_nxt[15:8] = in_data_byte;
      end
    end
  end

  // Advance the scan; clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      recent_r    <= '0;
      hdr_seen_r  <= 1'b0;
      hdr_off_r   <= '0;
      eocd_seen_r <= 1'b0;
      eocd_off_r  <= '0;
      cmt_r       <= '0;
    end else if (accept) begin
      if (in_last_byte) begin
        pos_r       <= '0;
        recent_r    <= '0;
        hdr_seen_r  <= 1'b0;
        hdr_off_r   <= '0;
        eocd_seen_r <= 1'b0;
        eocd_off_r  <= '0;
        cmt_r       <= '0;
      end else begin
        pos_r       <= pos_r + P'(1);
        recent_r    <= window[23:0];
        hdr_seen_r  <= hdr_seen_nxt;
        hdr_off_r   <= hdr_off_nxt;
        eocd_seen_r <= eocd_seen_nxt;
        eocd_off_r  <= eocd_off_nxt;
        cmt_r       <= cmt_nxt;
      end
    end
  end

  // Snapshot valid: set by a final byte, drop when the result stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (accept && in_last_byte) begin
      fin_valid_r <= 1'b1;
    end else if (fin_take) begin
      fin_valid_r <= 1'b0;
    end
  end

  // Hold the snapshot payload
  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      fin_flags_r.hdr_seen  <= hdr_seen_nxt;
      fin_flags_r.eocd_seen <= eocd_seen_nxt;
      fin_pos_r             <= pos_r;
      fin_hdr_off_r         <= hdr_off_nxt;
      fin_eocd_off_r        <= eocd_off_nxt;
      fin_cmt_r             <= cmt_nxt;
    end
  end

  assign fin_valid    = fin_valid_r;
  assign fin_flags    = fin_flags_r;
  assign fin_pos      = fin_pos_r;
  assign fin_hdr_off  = fin_hdr_off_r;
  assign fin_eocd_off = fin_eocd_off_r;
  assign fin_cmt      = fin_cmt_r;

  // A final byte restarts the scan and fills the snapshot
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> fin_valid_r && pos_r == '0 && !hdr_seen_r && !eocd_seen_r)
    else $error("scan state not cleared after final byte");

  // A header offset is only kept once a header was seen
  a_hdr_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !hdr_seen_r |-> hdr_off_r == '0)
    else $error("header offset set without a header");

endmodule

[rtl/embedded_zip_locator_unit.sv]
// Embedded ZIP locator.
// Input channel (in_valid/in_ready): one file byte per request, with
// in_last_byte high on the file's final byte. The block finds the first
// local-header signature and the last end-of-central-directory record.
// Result channel (out_valid/out_ready): one result per file, issued for
// the final byte: out_status, out_zip_start and out_zip_length.
// Throughput: one byte per cycle while in_ready is high, set by the
// combinational signature match and offset update in the scanner.
// Result path: a finished file moves from the snapshot register into the
// result register once that is free or being taken, and out_valid rises
// when the result register loads.
// Stall: a finished file waits in the snapshot register while the result
// register is held; bytes keep flowing until both are full, and then
// in_ready drops until out_ready takes the pending result.
// Reset (rst_n low, synchronous): clears the scan state and both valid
// flags; the next byte accepted is offset zero of a new file.
module embedded_zip_locator_unit #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_zip_start,
  output logic [31:0] out_zip_length
);

  localparam int P  = POSITION_BITS;
  localparam int CW = ((P > 17) ? P : 17) + 1;
  localparam int OW = (P > 32) ? P : 32;

  logic                 fin_valid;
  logic                 fin_take;
  ezl_pkg::ezl_flags_t  fin_flags;
  logic [P-1:0]         fin_pos;
  logic [P-1:0]         fin_hdr_off;
  logic [P-1:0]         fin_eocd_off;
  logic [15:0]          fin_cmt;

  logic                 out_adv;
  logic                 out_valid_r;
  ezl_pkg::status_t     status_r;
  logic [31:0]          zip_start_r;
  logic [31:0]          zip_length_r;

  ezl_pkg::status_t     status_nxt;
  logic [31:0]          zip_length_nxt;
  logic [31:0]          zip_start_nxt;
  logic [P-1:0]         tail;
  logic [CW-1:0]        need;
  logic [P-1:0]         len_p;
  logic [OW-1:0]        len_w;
  logic [OW-1:0]        start_w;

  assign out_adv  = !out_valid_r || out_ready;
  assign fin_take = fin_valid && out_adv;

  ezl_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .fin_take     (fin_take),
    .fin_valid    (fin_valid),
    .fin_flags    (fin_flags),
    .fin_pos      (fin_pos),
    .fin_hdr_off  (fin_hdr_off),
    .fin_eocd_off (fin_eocd_off),
    .fin_cmt      (fin_cmt)
  );

  // Size arithmetic on the finished file
  assign tail    = fin_pos - fin_eocd_off;
  assign need    = CW'(ezl_pkg::EOCD_FIXED_SIZE - 1) + CW'(fin_cmt);
  assign len_p   = fin_eocd_off - fin_hdr_off + P'(ezl_pkg::EOCD_FIXED_SIZE) + P'(fin_cmt);
  assign len_w   = OW'(len_p);
  assign start_w = OW'(fin_hdr_off);
  assign zip_start_nxt = start_w[31:0];

  // Pick the status in precedence order
  always_comb begin
    zip_length_nxt = '0;
    priority if (!fin_flags.hdr_seen) begin
      status_nxt = ezl_pkg::ST_NO_HDR;
    end else if (!fin_flags.eocd_seen) begin
      status_nxt = ezl_pkg::ST_NO_EOCD;
    end else if (CW'(tail) < CW'(ezl_pkg::CMT_OFFSET + 1)) begin
      status_nxt = ezl_pkg::ST_TRUNC;
    end else if (fin_eocd_off < fin_hdr_off) begin
      status_nxt = ezl_pkg::ST_BAD_SIZE;
    end else if (CW'(tail) < need) begin
      status_nxt = ezl_pkg::ST_BAD_SIZE;
    end else begin
      status_nxt     = ezl_pkg::ST_OK;
      zip_length_nxt = len_w[31:0];
    end
  end

  // Result valid: load from the snapshot, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= fin_valid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (fin_take) begin
      status_r     <= status_nxt;
      zip_start_r  <= zip_start_nxt;
      zip_length_r <= zip_length_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_zip_start  = zip_start_r;
  assign out_zip_length = zip_length_r;

  // Length is reported only for a good archive
  a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ezl_pkg::ST_OK |-> out_zip_length == '0)
    else $error("length reported with a failing status");

  // No header means no start offset
  a_no_hdr_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ezl_pkg::ST_NO_HDR |-> out_zip_start == '0)
    else $error("start offset reported without a header");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ezl_pkg::ST_BAD_SIZE)
    else $error("undefined status code");

  // A pending snapshot moves into a free result register
  a_snapshot_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !out_valid_r |=> out_valid_r)
    else $error("snapshot not moved to the result register");

endmodule
